// ===== rtl/html_entity_decoder_core_assert.svh =====
// Assertion macros used by the HTML entity decoder front end.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef HTML_ENTITY_DECODER_CORE_ASSERT_SVH
`define HTML_ENTITY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hed_pkg.sv =====
// Package for the HTML entity decoder: entity tables, sizes and the command type.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package hed_pkg;

  localparam int ENT_COUNT  = 9;
  localparam int HOLD_DEPTH = 6;
  localparam int WIN_DEPTH  = HOLD_DEPTH + 1;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] AMP_CHAR = "&";

  // Entity text, right-aligned; index 0 is in the lowest bits.
  localparam logic [ENT_COUNT-1:0][55:0] ENT_TEXT = {
    "&rsquo;",
    "&times;",
    "&rdquo;",
    "&ldquo;",
    {16'h0, "&#39;"},
    {24'h0, "&lt;"},
    {8'h0,  "&quot;"},
    {16'h0, "&amp;"},
    {24'h0, "&gt;"}
  };

  localparam logic [ENT_COUNT-1:0][2:0] ENT_LEN = {
    3'd7, 3'd7, 3'd7, 3'd7, 3'd5, 3'd4, 3'd6, 3'd5, 3'd4
  };

  localparam logic [ENT_COUNT-1:0][7:0] ENT_REPL = {
    "'", "*", "\"", "\"", "'", "<", "\"", "&", ">"
  };

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } hed_cmd_t;

  function automatic logic [7:0] ent_char(input logic [55:0] text,
                                          input logic [2:0]  len,
                                          input logic [2:0]  pos);
    logic [2:0] idx;
    idx = len - 3'd1 - pos;
    return text[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hed_front.sv =====
// Front end of the HTML entity decoder: accepts bytes, tracks the entity prefix
// and issues emit commands. Depends on hed_pkg and the assertion macro header.
`default_nettype none
`include "html_entity_decoder_core_assert.svh"

module hed_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tlast,
  input  wire logic              q_full,
  output logic                   q_push,
  output hed_pkg::hed_cmd_t      q_cmd
);

  logic [2:0]                           held_r, held_nxt;
  logic [hed_pkg::ENT_COUNT-1:0]        alive_r, alive_nxt;
  logic [hed_pkg::HOLD_DEPTH-1:0][7:0]  pend_r;
  logic [hed_pkg::ENT_COUNT-1:0]        match;
  logic [hed_pkg::ENT_COUNT-1:0]        full;
  logic [7:0]                           rep;
  logic [2:0]                           n;
  logic                                 in_fire;
  logic                                 is_amp;
  logic                                 pend_wr;
  logic [2:0]                           pend_idx;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign n         = held_r + 3'd1;
  assign is_amp    = (in_tdata == hed_pkg::AMP_CHAR);

  always_comb begin
    rep = 8'h00;
    for (int e = 0; e < hed_pkg::ENT_COUNT; e++) begin
      match[e] = alive_r[e] && (held_r < hed_pkg::ENT_LEN[e]) &&
                 (hed_pkg::ent_char(hed_pkg::ENT_TEXT[e], hed_pkg::ENT_LEN[e], held_r)
                  == in_tdata);
      full[e]  = match[e] && (n == hed_pkg::ENT_LEN[e]);
      if (full[e]) begin
        rep = hed_pkg::ENT_REPL[e];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < hed_pkg::HOLD_DEPTH; i++) begin
      q_cmd.bytes[i] = (held_r == 3'(i)) ? in_tdata : pend_r[i];
    end
    q_cmd.bytes[hed_pkg::WIN_DEPTH-1] = in_tdata;
    q_cmd.cnt  = 3'd0;
    q_cmd.last = in_tlast;
    held_nxt   = held_r;
    alive_nxt  = alive_r;
    pend_wr    = 1'b0;
    pend_idx   = 3'd0;
    if (held_r == 3'd0) begin
      if (is_amp && !in_tlast) begin
        held_nxt  = 3'd1;
        alive_nxt = '1;
        pend_wr   = 1'b1;
      end else begin
        q_cmd.cnt = 3'd1;
      end
    end else if (|full) begin
      q_cmd.bytes[0] = rep;
      q_cmd.cnt      = 3'd1;
      held_nxt       = 3'd0;
    end else if (|match) begin
      if (in_tlast) begin
        q_cmd.cnt = n;
        held_nxt  = 3'd0;
      end else begin
        held_nxt  = n;
        alive_nxt = match;
        pend_wr   = 1'b1;
        pend_idx  = held_r;
      end
    end else if (is_amp && !in_tlast) begin
      q_cmd.cnt = held_r;
      held_nxt  = 3'd1;
      alive_nxt = '1;
      pend_wr   = 1'b1;
    end else begin
      q_cmd.cnt = n;
      held_nxt  = 3'd0;
    end
  end

  assign q_push = in_fire && (q_cmd.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 3'd0;
      alive_r <= '0;
    end else if (in_fire) begin
      held_r  <= held_nxt;
      alive_r <= alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && pend_wr) begin
      pend_r[pend_idx] <= in_tdata;
    end
  end

  `HED_ASSERT_NOW(a_held_bound, 1'b1, held_r <= 3'(hed_pkg::HOLD_DEPTH),
                  "held byte count exceeds hold depth")
  `HED_ASSERT_NOW(a_held_amp, held_r != 3'd0, pend_r[0] == hed_pkg::AMP_CHAR,
                  "held run does not start with an ampersand")
  `HED_ASSERT_NOW(a_held_alive, held_r != 3'd0, alive_r != '0,
                  "held run matches no entity")
  `HED_ASSERT_NEXT(a_last_clears, in_fire && in_tlast, held_r == 3'd0,
                   "bytes still held after the last item")

endmodule

`default_nettype wire

// ===== rtl/hed_queue.sv =====
// Two-entry command queue between the front and back ends of the decoder.
// Depends on hed_pkg for the command type and depth.
`default_nettype none

module hed_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hed_pkg::hed_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output hed_pkg::hed_cmd_t      head
);

  localparam int PTR_W = $clog2(hed_pkg::QDEPTH);
  localparam int CNT_W = $clog2(hed_pkg::QDEPTH + 1);

  hed_pkg::hed_cmd_t  mem_r [hed_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full      = (cnt_r == CNT_W'(hed_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hed_back.sv =====
// Back end of the HTML entity decoder: plays out queued commands one byte per
// cycle, while the output is accepted, into the output register. Depends on hed_pkg.
`default_nettype none

module hed_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire hed_pkg::hed_cmd_t q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       advance;
  logic       load;
  logic       at_end;

  assign advance = !out_valid_r || out_tready;
  assign load    = advance && q_valid;
  assign at_end  = (idx_r == (q_head.cnt - 3'd1));
  assign q_pop   = load && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = q_valid;
    end
    if (load) begin
      idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= q_head.bytes[idx_r];
      out_last_r <= q_head.last && at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/html_entity_decoder_core.sv =====
// Top level of the HTML entity decoder: front end, command queue and back end.
// Depends on hed_pkg, hed_front, hed_queue and hed_back.
//
// The decoder takes one text byte per cycle while the queue is not full, and
// produces one decoded byte per cycle while the output is accepted. A byte
// that passes through or completes an entity yields one result; a byte that
// breaks a partial entity, or the last byte of a stream, yields the held bytes
// as well, up to seven results, played out one by one. A two-command queue
// sits between front and back, so input stalls only once the back end falls
// two commands behind; each result passes the queue and the output register.
`default_nettype none

module html_entity_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);

  hed_pkg::hed_cmd_t push_cmd;
  hed_pkg::hed_cmd_t head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_valid;

  hed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  hed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  hed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
